// ===== src/i2cms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i2cms_pkg;

    // Command codes as they arrive on the operation field
    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ      = 3'd3,
        OP_SEND_ACK  = 3'd4,
        OP_READ_ACK  = 3'd5
    } t_op;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [2:0]  BIT_LAST    = 3'd7;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       ack;
        logic [7:0] bus;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage
`default_nettype wire

// ===== src/i2cms_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cms_front (
    input  wire logic              i_valid,
    input  wire logic [2:0]        i_operation,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_ack_level,
    input  wire logic [7:0]        i_bus_levels,
    input  wire logic              i_full,
    output      logic              o_stall,
    output      i2cms_pkg::t_push  o_push
);

    logic w_op_ok;

    // Unused codes are taken and dropped: they make no pin writes
    assign w_op_ok = (i_operation <= i2cms_pkg::OP_READ_ACK);
    assign o_stall = i_full;

    always_comb begin
        o_push.valid    = i_valid && !i_full && w_op_ok;
        o_push.cmd.op   = i2cms_pkg::t_op'(i_operation);
        o_push.cmd.data = i_data_byte;
        o_push.cmd.ack  = i_ack_level;
        o_push.cmd.bus  = i_bus_levels;
    end

endmodule
`default_nettype wire

// ===== src/i2cms_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cms_queue #(
    parameter int unsigned DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire i2cms_pkg::t_push i_push,
    input  wire logic             i_pop,
    output      logic             o_full,
    output      logic             o_not_empty,
    output      i2cms_pkg::t_cmd  o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    i2cms_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd];
    assign w_push      = i_push.valid && !o_full;
    assign w_pop       = i_pop && o_not_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/i2cms_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cms_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_not_empty,
    input  wire i2cms_pkg::t_cmd i_q_cmd,
    output      logic            o_pop,
    output      logic            o_valid,
    input  wire logic            i_stall,
    output      logic            o_scl_level,
    output      logic            o_sda_level,
    output      logic            o_last_write,
    output      logic [7:0]      o_read_byte,
    output      logic            o_ack_seen
);

    i2cms_pkg::t_state r_state, n_state;
    i2cms_pkg::t_cmd   r_cmd;
    logic [1:0]        r_phase, n_phase;
    logic [2:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              w_last;
    logic [7:0]        w_rb;
    logic              w_ack;
    logic              w_adv;

    logic              r_out_valid, n_out_valid;
    logic              r_out_scl, r_out_sda, r_out_last, r_out_ack;
    logic [7:0]        r_out_rb;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2cms_pkg::ST_IDLE: begin
                if (i_q_not_empty) begin
                    n_state = i2cms_pkg::ST_RUN;
                end
            end
            i2cms_pkg::ST_RUN: begin
                if (w_adv && w_last) begin
                    n_state = i2cms_pkg::ST_IDLE;
                end
            end
            default: n_state = i2cms_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop = 1'b0;
        w_adv = 1'b0;
        unique case (r_state)
            i2cms_pkg::ST_IDLE: o_pop = i_q_not_empty;
            i2cms_pkg::ST_RUN:  w_adv = !r_out_valid || !i_stall;
            default: begin
                o_pop = 1'b0;
                w_adv = 1'b0;
            end
        endcase
    end

    // Pin write for the current step of the command
    always_comb begin
        n_scl   = r_scl;
        n_sda   = r_sda;
        w_last  = 1'b0;
        w_rb    = '0;
        w_ack   = 1'b0;
        n_phase = r_phase + 2'd1;
        n_bit   = r_bit;
        n_shift = r_shift;
        unique case (r_cmd.op)
            i2cms_pkg::OP_START: begin
                unique case (r_phase)
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end
                endcase
            end
            i2cms_pkg::OP_STOP: begin
                unique case (r_phase)
                    2'd0:    n_sda = 1'b0;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_sda  = 1'b1;
                        w_last = 1'b1;
                    end
                endcase
            end
            i2cms_pkg::OP_WRITE: begin
                unique case (r_phase)
                    2'd0:    n_sda = r_shift[7];
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl   = 1'b0;
                        n_phase = 2'd0;
                        n_bit   = r_bit + 3'd1;
                        n_shift = {r_shift[6:0], 1'b0};
                        w_last  = (r_bit == i2cms_pkg::BIT_LAST);
                    end
                endcase
            end
            i2cms_pkg::OP_READ: begin
                unique case (r_phase)
                    2'd0:    n_scl = 1'b1;
                    default: begin
                        n_scl   = 1'b0;
                        n_phase = 2'd0;
                        n_bit   = r_bit + 3'd1;
                        w_last  = (r_bit == i2cms_pkg::BIT_LAST);
                        w_rb    = w_last ? r_cmd.bus : 8'd0;
                    end
                endcase
            end
            i2cms_pkg::OP_SEND_ACK: begin
                unique case (r_phase)
                    2'd0:    n_sda = r_cmd.ack;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end
                endcase
            end
            i2cms_pkg::OP_READ_ACK: begin
                unique case (r_phase)
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                        w_ack  = r_cmd.bus[7];
                    end
                endcase
            end
            default: w_last = 1'b1;
        endcase
    end

    always_comb begin
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2cms_pkg::ST_IDLE;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_bit       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_phase <= '0;
                r_bit   <= '0;
            end else if (w_adv) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_q_cmd;
            r_shift <= i_q_cmd.data;
        end else if (w_adv) begin
            r_shift <= n_shift;
        end
        if (w_adv) begin
            r_out_scl  <= n_scl;
            r_out_sda  <= n_sda;
            r_out_last <= w_last;
            r_out_rb   <= w_rb;
            r_out_ack  <= w_ack;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_scl_level  = r_out_scl;
    assign o_sda_level  = r_out_sda;
    assign o_last_write = r_out_last;
    assign o_read_byte  = r_out_rb;
    assign o_ack_seen   = r_out_ack;

endmodule
`default_nettype wire

// ===== src/i2c_master_bit_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Command to pin writes: one pin write leaves per cycle while a command runs and the
// output is not stalled. A command leaves the queue first; the back-end sequencer then
// makes 4 (start), 3 (stop, acks), 16 (read byte) or 24 (write byte) pin writes.
// A command accepted into an idle block passes the queue, the pop into the back end and
// the output register before its first pin write appears; unused codes make none.
// Synchronous active-low reset: queue empty, output empty, held line levels released high.
module i2c_master_bit_sequencer_unit #(
    parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // command side
    input  wire logic       i_valid,
    output      logic       o_stall,
    input  wire logic [2:0] i_operation,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_ack_level,
    input  wire logic [7:0] i_bus_levels,
    // pin write side
    output      logic       o_valid,
    input  wire logic       i_stall,
    output      logic       o_scl_level,
    output      logic       o_sda_level,
    output      logic       o_last_write,
    output      logic [7:0] o_read_byte,
    output      logic       o_ack_seen
);

    i2cms_pkg::t_push w_push;
    i2cms_pkg::t_cmd  w_q_cmd;
    logic             w_full;
    logic             w_not_empty;
    logic             w_pop;

    // Front: take each transaction, drop unused codes, push the rest
    i2cms_front u_front (
        .i_valid      (i_valid),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .i_ack_level  (i_ack_level),
        .i_bus_levels (i_bus_levels),
        .i_full       (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push)
    );

    // Short queue: lets the front keep taking commands while the back runs
    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_q_cmd)
    );

    // Back: step through the pin writes of one command, hold the line levels
    i2cms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (w_not_empty),
        .i_q_cmd       (w_q_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_last_write  (o_last_write),
        .o_read_byte   (o_read_byte),
        .o_ack_seen    (o_ack_seen)
    );

endmodule
`default_nettype wire

// ===== src/i2cms_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cms_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_scl_level,
    input wire logic       o_sda_level,
    input wire logic       o_last_write,
    input wire logic [7:0] o_read_byte,
    input wire logic       o_ack_seen
);

    // Nothing leaves straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pin write shown right after reset");

    // A stalled pin write stays on offer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_scl_level) && $stable(o_sda_level))
        else $error("stalled pin write dropped or changed");

    // Sampled fields are only set on the final write of a command
    a_sample_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_write |-> o_read_byte == 8'd0 && !o_ack_seen)
        else $error("sampled data outside final write");

    // Every command ends with the clock low, except stop which ends with data released
    a_end_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_write |-> !o_scl_level || o_sda_level)
        else $error("command ended with clock high and data low");

    // A seen ack comes with the clock low and data released
    a_ack_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ack_seen |-> o_last_write && !o_scl_level && o_sda_level)
        else $error("ack reported on wrong write");

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_i2cms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_scl_level  (o_scl_level),
    .o_sda_level  (o_sda_level),
    .o_last_write (o_last_write),
    .o_read_byte  (o_read_byte),
    .o_ack_seen   (o_ack_seen)
);
`default_nettype wire
